// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the pulse encoder modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define LSPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define LSPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lspe_pkg.sv =====
// ----------------------------------------------------------------------------
// lspe_pkg
// Types and constants of the LED strip pulse encoder
// ----------------------------------------------------------------------------
package lspe_pkg;

  localparam int unsigned PERIOD_W = 11;
  localparam int unsigned HIGH_W   = 10;
  localparam int unsigned RP_W     = 8;
  localparam int unsigned DUR_W    = 18;
  localparam int unsigned WORD_W   = 24;
  localparam int unsigned SEG_W    = 6;
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned IDX_W    = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 11'd2;
  localparam logic [DUR_W-1:0]    DUR_MAX    = 18'h3FFFF;
  localparam logic [SEG_W-1:0]    LAST_BIT_SEG = 6'd47;
  localparam logic [SEG_W-1:0]    LATCH_SEG    = 6'd48;

  typedef enum logic [1:0] {
    SEG_HIGH  = 2'd0,
    SEG_LOW   = 2'd1,
    SEG_LATCH = 2'd2
  } seg_kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_BIT_PERIOD    = 3'd0,
    REG_ZERO_HIGH     = 3'd1,
    REG_ONE_HIGH      = 3'd2,
    REG_COLOR_ORDER   = 3'd3,
    REG_INVERT_LINE   = 3'd4,
    REG_RESET_PERIODS = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] bit_period;
    logic [HIGH_W-1:0]   zero_high;
    logic [HIGH_W-1:0]   one_high;
    logic                color_order;
    logic                invert_line;
    logic [RP_W-1:0]     reset_periods;
  } lspe_cfg_t;

  // one classified pixel as it waits for the back end
  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic                last;
    logic [PERIOD_W-1:0] period;
    logic [HIGH_W-1:0]   t0;
    logic [HIGH_W-1:0]   t1;
    logic [DUR_W-1:0]    latch;
    logic                inv;
  } pix_entry_t;

endpackage

// ===== rtl/led_strip_pulse_encoder.sv =====
// ----------------------------------------------------------------------------
// led_strip_pulse_encoder
// One-wire addressable LED pulse encoder: pixels in, line segments out
// ----------------------------------------------------------------------------
// a pixel passes the pixel queue and the back end pixel register; its segments leave
//   the back end output register one per cycle while out_ready is high,
//   48 segments per pixel, 49 for a pixel that ends the frame
// a 2-entry pixel queue lets the input keep taking pixels while segments stall
// reset (synchronous, rst_n low) empties queue and output, loads default timing
module led_strip_pulse_encoder
  import lspe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        in_last_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_line_level,
  output logic [17:0] out_duration_ticks,
  output logic [1:0]  out_segment_kind,
  output logic        out_last_segment
);

  lspe_cfg_t  cfg_r;
  logic       q_push, q_pop, q_full, q_not_empty;
  pix_entry_t q_wdata, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_period    <= 11'd75;
      cfg_r.zero_high     <= 10'd24;
      cfg_r.one_high      <= 10'd48;
      cfg_r.color_order   <= 1'b0;
      cfg_r.invert_line   <= 1'b0;
      cfg_r.reset_periods <= 8'd60;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BIT_PERIOD:    cfg_r.bit_period    <= cfg_wdata;
        REG_ZERO_HIGH:     cfg_r.zero_high     <= cfg_wdata[HIGH_W-1:0];
        REG_ONE_HIGH:      cfg_r.one_high      <= cfg_wdata[HIGH_W-1:0];
        REG_COLOR_ORDER:   cfg_r.color_order   <= cfg_wdata[0];
        REG_INVERT_LINE:   cfg_r.invert_line   <= cfg_wdata[0];
        REG_RESET_PERIODS: cfg_r.reset_periods <= cfg_wdata[RP_W-1:0];
        default: ;
      endcase
    end
  end

  lspe_front u_front (
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_last_pixel (in_last_pixel),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  lspe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lspe_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_not_empty        (q_not_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_line_level     (out_line_level),
    .out_duration_ticks (out_duration_ticks),
    .out_segment_kind   (out_segment_kind),
    .out_last_segment   (out_last_segment)
  );

endmodule

// ===== rtl/lspe_front.sv =====
// ----------------------------------------------------------------------------
// lspe_front
// Accepts pixels, orders the color bytes and clamps the bit timing
// ----------------------------------------------------------------------------
module lspe_front
  import lspe_pkg::*;
(
  input  lspe_cfg_t  cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       in_last_pixel,
  input  logic       q_full,
  output logic       q_push,
  output pix_entry_t q_data
);

  logic [PERIOD_W-1:0]      period;
  logic [RP_W+PERIOD_W-1:0] latch_full;

  always_comb begin
    period = (cfg.bit_period < PERIOD_MIN) ? PERIOD_MIN : cfg.bit_period;
    q_data.period = period;
    q_data.t0 = ({1'b0, cfg.zero_high} >= period) ?
                HIGH_W'(period - 11'd1) : cfg.zero_high;
    q_data.t1 = ({1'b0, cfg.one_high} >= period) ?
                HIGH_W'(period - 11'd1) : cfg.one_high;
    latch_full = (RP_W+PERIOD_W)'(cfg.reset_periods) * (RP_W+PERIOD_W)'(period);
    // 8x11 product can exceed the 18-bit duration field
    q_data.latch = (latch_full > (RP_W+PERIOD_W)'(DUR_MAX)) ?
                   DUR_MAX : latch_full[DUR_W-1:0];
    q_data.word = cfg.color_order ? {in_red, in_green, in_blue}
                                  : {in_green, in_red, in_blue};
    q_data.last = in_last_pixel;
    q_data.inv  = cfg.invert_line;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== rtl/lspe_fifo.sv =====
// ----------------------------------------------------------------------------
// lspe_fifo
// Short queue of classified pixels between front and back end
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lspe_fifo
  import lspe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pix_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output pix_entry_t head
);

  localparam int unsigned ADDR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  pix_entry_t          mem_r [QDEPTH];
  logic [ADDR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r, count_nxt;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    ptr_inc = (p == ADDR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count_r == CNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  `LSPE_ASSERT(a_no_overflow, !(push && full), "push into full queue")
  `LSPE_ASSERT(a_no_underflow, !(pop && !not_empty), "pop from empty queue")

endmodule

// ===== rtl/lspe_back.sv =====
// ----------------------------------------------------------------------------
// lspe_back
// Walks one pixel's bits and emits one line segment per cycle unless the output stalls
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lspe_back
  import lspe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  pix_entry_t        q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_line_level,
  output logic [DUR_W-1:0]  out_duration_ticks,
  output logic [1:0]        out_segment_kind,
  output logic              out_last_segment
);

  pix_entry_t         cur_r;
  logic               cur_v_r;
  logic [SEG_W-1:0]   seg_r;
  logic               out_valid_r, out_valid_nxt;
  logic               level_r, level_nxt;
  logic [DUR_W-1:0]   dur_r, dur_nxt;
  seg_kind_t          kind_r, kind_nxt;
  logic               lastseg_r, lastseg_nxt;

  logic               emit, done, load;
  logic [HIGH_W-1:0]  hi;

  always_comb begin
    emit = cur_v_r && (!out_valid_r || out_ready);
    done = (seg_r == LAST_BIT_SEG && !cur_r.last) || (seg_r == LATCH_SEG);
    load = q_not_empty && (!cur_v_r || (emit && done));
    hi   = cur_r.word[WORD_W-1] ? cur_r.t1 : cur_r.t0;

    if (seg_r == LATCH_SEG) begin
      level_nxt   = cur_r.inv;
      dur_nxt     = cur_r.latch;
      kind_nxt    = SEG_LATCH;
      lastseg_nxt = 1'b1;
    end else if (!seg_r[0]) begin
      level_nxt   = !cur_r.inv;
      dur_nxt     = DUR_W'(hi);
      kind_nxt    = SEG_HIGH;
      lastseg_nxt = 1'b0;
    end else begin
      level_nxt   = cur_r.inv;
      dur_nxt     = DUR_W'(cur_r.period - PERIOD_W'(hi));
      kind_nxt    = SEG_LOW;
      lastseg_nxt = (seg_r == LAST_BIT_SEG) && !cur_r.last;
    end

    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r     <= 1'b0;
      seg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        cur_v_r <= 1'b1;
        seg_r   <= '0;
      end else if (emit) begin
        if (done) cur_v_r <= 1'b0;
        else      seg_r   <= seg_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_head;
    end else if (emit && seg_r[0]) begin
      // next bit moves to the top after its low part
      cur_r.word <= {cur_r.word[WORD_W-2:0], 1'b0};
    end
    if (emit) begin
      level_r   <= level_nxt;
      dur_r     <= dur_nxt;
      kind_r    <= kind_nxt;
      lastseg_r <= lastseg_nxt;
    end
  end

  assign q_pop              = load;
  assign out_valid          = out_valid_r;
  assign out_line_level     = level_r;
  assign out_duration_ticks = dur_r;
  assign out_segment_kind   = kind_r;
  assign out_last_segment   = lastseg_r;

  `LSPE_ASSERT(a_seg_range, !cur_v_r || (seg_r <= LATCH_SEG), "segment index out of range")
  `LSPE_ASSERT(a_latch_only_last, !(cur_v_r && seg_r == LATCH_SEG) || cur_r.last, "latch on non-final pixel")
  `LSPE_ASSERT(a_latch_is_final, !(out_valid_r && kind_r == SEG_LATCH) || lastseg_r, "latch segment not flagged final")
  `LSPE_ASSERT_NEXT(a_load_start, load, cur_v_r && seg_r == '0, "pixel load did not restart segments")

endmodule
